// ===== rtl/particle_pool_update_assert.svh =====
// Assertion helpers; clk and arst_n come from the including module.
`ifndef PARTICLE_POOL_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PPU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent checked in the following cycle.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppu_pkg.sv =====
package ppu_pkg;

	localparam logic [15:0] FADE_RESET = 16'd6144;
	localparam logic signed [23:0] LIFE_MIN = -24'sd8388608;
	localparam logic signed [15:0] ALPHA_MIN = -16'sd32768;

	typedef struct packed {
		logic [15:0] elapsed;
		logic [6:0] spawn_count;
		logic signed [23:0] spawn_x;
		logic signed [23:0] spawn_y;
		logic signed [23:0] speed_x;
		logic signed [23:0] speed_y;
		logic [12:0] gray_level;
		logic [12:0] opacity;
		logic [22:0] lifetime;
		logic [15:0] sprite_width;
		logic [15:0] sprite_height;
	} in_item_t;

	typedef struct packed {
		logic [5:0] slot;
		logic alive;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic [12:0] out_gray;
		logic signed [15:0] out_alpha;
		logic [15:0] out_width;
		logic [15:0] out_height;
		logic last_slot;
	} out_item_t;

	// One pool entry as held in the RAM.
	typedef struct packed {
		logic signed [23:0] life;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [12:0] gray;
		logic signed [15:0] alpha;
		logic [15:0] width;
		logic [15:0] height;
	} part_rec_t;

	// Write-back from the aging datapath.
	typedef struct packed {
		logic vld;
		logic [5:0] slot;
		logic alive;
		logic last;
		part_rec_t rec;
	} age_wb_t;

endpackage

// ===== rtl/ppu_ram.sv =====
module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/ppu_age.sv =====
module ppu_age (
	input logic clk,
	input logic arst_n,
	input logic v_s1,
	input logic [5:0] slot_s1,
	input logic last_s1,
	input ppu_pkg::part_rec_t rec_s1,
	input logic [15:0] dt,
	input logic [19:0] fade,
	output ppu_pkg::age_wb_t wb
);
	import ppu_pkg::*;

	logic signed [24:0] life_d;
	logic signed [23:0] life_sat;
	logic signed [40:0] prod_x, prod_y;

	logic v_s2;
	logic [5:0] slot_s2;
	logic last_s2;
	part_rec_t rec_s2;
	logic signed [23:0] life_s2;
	logic signed [40:0] prod_x_s2, prod_y_s2;

	logic signed [21:0] alpha_d;
	part_rec_t rec_n;
	logic move;

	always_comb begin
		life_d = $signed({rec_s1.life[23], rec_s1.life}) - $signed({9'd0, dt});
		life_sat = (life_d < $signed({LIFE_MIN[23], LIFE_MIN})) ? LIFE_MIN : life_d[23:0];
		prod_x = rec_s1.vel_x * $signed({1'b0, dt});
		prod_y = rec_s1.vel_y * $signed({1'b0, dt});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		slot_s2 <= slot_s1;
		last_s2 <= last_s1;
		rec_s2 <= rec_s1;
		life_s2 <= life_sat;
		prod_x_s2 <= prod_x;
		prod_y_s2 <= prod_y;
	end

	always_comb begin
		move = !life_s2[23];
		alpha_d = $signed({{6{rec_s2.alpha[15]}}, rec_s2.alpha}) - $signed({2'b00, fade});
		rec_n = rec_s2;
		rec_n.life = life_s2;
		if (move) begin
			// arithmetic shift of the product floors toward minus infinity
			rec_n.pos_x = rec_s2.pos_x + prod_x_s2[35:12];
			rec_n.pos_y = rec_s2.pos_y + prod_y_s2[35:12];
			rec_n.alpha = (alpha_d < $signed({{6{ALPHA_MIN[15]}}, ALPHA_MIN})) ?
				ALPHA_MIN : alpha_d[15:0];
		end
		wb.vld = v_s2;
		wb.slot = slot_s2;
		wb.alive = (life_s2 > 24'sd0);
		wb.last = last_s2;
		wb.rec = rec_n;
	end
endmodule

// ===== rtl/particle_pool_update.sv =====
// Particle pool: a fixed set of POOL_SIZE entries updated once per tick.
// A tick transaction is taken when start is high and busy is low; item carries
// the elapsed time, the spawn count and the template particle. cfg_we with
// cfg_wdata sets the alpha fade rate (write only while busy is low).
// Spawn phase: each copy scans the free-slot flags from the search pointer,
// one slot per cycle, and writes its slot in the cycle the scan ends.
// Aging phase: one entry per cycle read from the RAM, aged in a read / multiply /
// write-back pipeline; each slot is written back and shown on res for one cycle
// with res_valid, slots 0 .. POOL_SIZE-1 in order, last_slot on the final one;
// busy drops the cycle after the last result.
// The receiver cannot stall; results are never held.
// Reset: all entries read as zero (free) through per-entry valid flags, the
// search pointer is zero and the fade rate is 1.5; no clearing pass is needed.
module particle_pool_update #(
	parameter int POOL_SIZE = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ppu_pkg::in_item_t item,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	output logic res_valid,
	output ppu_pkg::out_item_t res
);
	import ppu_pkg::*;

	localparam int AW = $clog2(POOL_SIZE);
	localparam logic [AW-1:0] LAST_IDX = AW'(POOL_SIZE - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SPAWN = 2'd1;
	localparam logic [1:0] ST_AGE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0] state_q;
	logic [15:0] fade_rate_q;
	in_item_t tpl_q;
	logic [19:0] fade_q;
	logic [6:0] remain_q;
	logic [AW-1:0] ptr_q, idx_q, chk_q, age_q;
	logic [POOL_SIZE-1:0] valid_q, free_q;

	logic v_s1, vld_s1, last_s1;
	logic [AW-1:0] slot_s1;
	part_rec_t ram_rd, rec_s1;
	age_wb_t wb;

	logic [31:0] fade_prod;
	logic spawn_wr;
	logic [AW-1:0] spawn_slot;
	part_rec_t spawn_rec;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	part_rec_t ram_wdata;

	assign busy = (state_q != ST_IDLE);
	assign fade_prod = fade_rate_q * item.elapsed;

	always_comb begin
		spawn_wr = 1'b0;
		spawn_slot = idx_q;
		if (state_q == ST_SPAWN) begin
			if (free_q[idx_q]) begin
				spawn_wr = 1'b1;
			end else if (chk_q == LAST_IDX) begin
				spawn_wr = 1'b1;
				spawn_slot = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
			end
		end
		spawn_rec.life = {1'b0, tpl_q.lifetime};
		spawn_rec.pos_x = tpl_q.spawn_x;
		spawn_rec.pos_y = tpl_q.spawn_y;
		spawn_rec.vel_x = tpl_q.speed_x;
		spawn_rec.vel_y = tpl_q.speed_y;
		spawn_rec.gray = tpl_q.gray_level;
		spawn_rec.alpha = {3'b000, tpl_q.opacity};
		spawn_rec.width = tpl_q.sprite_width;
		spawn_rec.height = tpl_q.sprite_height;
		ram_we = spawn_wr || wb.vld;
		ram_waddr = wb.vld ? wb.slot[AW-1:0] : spawn_slot;
		ram_wdata = wb.vld ? wb.rec : spawn_rec;
	end

	ppu_ram #(
		.WIDTH($bits(part_rec_t)),
		.DEPTH(POOL_SIZE)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(age_q),
		.rdata(ram_rd)
	);

	assign rec_s1 = vld_s1 ? ram_rd : '0;

	ppu_age u_age (
		.clk(clk),
		.arst_n(arst_n),
		.v_s1(v_s1),
		.slot_s1(6'(slot_s1)),
		.last_s1(last_s1),
		.rec_s1(rec_s1),
		.dt(tpl_q.elapsed),
		.fade(fade_q),
		.wb(wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fade_rate_q <= FADE_RESET;
			ptr_q <= '0;
			idx_q <= '0;
			chk_q <= '0;
			age_q <= '0;
			remain_q <= '0;
			valid_q <= '0;
			free_q <= '1;
			v_s1 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_AGE);
			res_valid <= wb.vld;
			if (cfg_we) begin
				fade_rate_q <= cfg_wdata;
			end
			if (wb.vld) begin
				valid_q[wb.slot[AW-1:0]] <= 1'b1;
				free_q[wb.slot[AW-1:0]] <= !wb.alive;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						remain_q <= item.spawn_count;
						idx_q <= ptr_q;
						chk_q <= '0;
						age_q <= '0;
						state_q <= (item.spawn_count != 7'd0) ? ST_SPAWN : ST_AGE;
					end
				end
				ST_SPAWN: begin
					if (spawn_wr) begin
						valid_q[spawn_slot] <= 1'b1;
						free_q[spawn_slot] <= (tpl_q.lifetime == 23'd0);
						ptr_q <= spawn_slot;
						idx_q <= spawn_slot;
						chk_q <= '0;
						remain_q <= remain_q - 7'd1;
						if (remain_q == 7'd1) begin
							state_q <= ST_AGE;
						end
					end else begin
						idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
						chk_q <= chk_q + 1'b1;
					end
				end
				ST_AGE: begin
					age_q <= age_q + 1'b1;
					if (age_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !wb.vld) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && start) begin
			tpl_q <= item;
			fade_q <= fade_prod[31:12];
		end
		vld_s1 <= valid_q[age_q];
		slot_s1 <= age_q;
		last_s1 <= (age_q == LAST_IDX);
		res.slot <= wb.slot;
		res.alive <= wb.alive;
		res.out_x <= wb.rec.pos_x;
		res.out_y <= wb.rec.pos_y;
		res.out_gray <= wb.rec.gray;
		res.out_alpha <= wb.rec.alpha;
		res.out_width <= wb.rec.width;
		res.out_height <= wb.rec.height;
		res.last_slot <= wb.last;
	end

`include "particle_pool_update_assert.svh"

	`PPU_ASSERT_IMPL(a_res_busy, res_valid, busy, "result outside a tick")
	`PPU_ASSERT_NEXT(a_last_end, res_valid && res.last_slot, !res_valid,
		"result after last slot")
	`PPU_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted tick did not run")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import ppu_pkg::*;

	localparam int NSLOT = 64;
	localparam int MAX_ERR_SHOW = 10;
	localparam longint CYCLE_LIMIT = 64'd40000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic res_valid;
	out_item_t res;

	particle_pool_update #(.POOL_SIZE(NSLOT)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res(res)
	);

	// shadow pool
	logic signed [23:0] p_life [NSLOT];
	logic signed [23:0] p_x [NSLOT];
	logic signed [23:0] p_y [NSLOT];
	logic signed [23:0] p_vx [NSLOT];
	logic signed [23:0] p_vy [NSLOT];
	logic [12:0] p_gray [NSLOT];
	logic signed [15:0] p_alpha [NSLOT];
	logic [15:0] p_w [NSLOT];
	logic [15:0] p_h [NSLOT];
	logic [5:0] p_ptr;
	logic [15:0] p_fade;

	out_item_t slot_reports[$];
	int n_err = 0;
	int n_dir_err = 0;
	int n_ticks = 0;
	int n_results = 0;
	longint cycles = 0;
	int idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint floor_div4096(longint p);
		if (p >= 0)
			return p >>> 12;
		return -((-p + 4095) >>> 12);
	endfunction

	function automatic logic [5:0] free_slot_pick();
		for (int i = p_ptr; i < NSLOT; i++)
			if (p_life[i] <= 0) begin
				p_ptr = 6'(i);
				return 6'(i);
			end
		for (int i = 0; i < p_ptr; i++)
			if (p_life[i] <= 0) begin
				p_ptr = 6'(i);
				return 6'(i);
			end
		p_ptr = p_ptr + 6'd1;
		return p_ptr;
	endfunction

	task automatic pool_tick(input in_item_t t);
		longint dt;
		longint fade;
		longint lf;
		longint a;
		logic [5:0] s;
		out_item_t o;
		dt = t.elapsed;
		fade = floor_div4096(longint'(p_fade) * dt);
		for (int k = 0; k < t.spawn_count; k++) begin
			s = free_slot_pick();
			p_x[s] = t.spawn_x;
			p_y[s] = t.spawn_y;
			p_vx[s] = t.speed_x;
			p_vy[s] = t.speed_y;
			p_gray[s] = t.gray_level;
			p_alpha[s] = {3'b000, t.opacity};
			p_life[s] = {1'b0, t.lifetime};
			p_w[s] = t.sprite_width;
			p_h[s] = t.sprite_height;
		end
		for (int k = 0; k < NSLOT; k++) begin
			lf = longint'(p_life[k]) - dt;
			if (lf < -8388608)
				lf = -8388608;
			p_life[k] = 24'(lf);
			if (lf >= 0) begin
				p_x[k] = p_x[k] + 24'(floor_div4096(longint'(p_vx[k]) * dt));
				p_y[k] = p_y[k] + 24'(floor_div4096(longint'(p_vy[k]) * dt));
				a = longint'(p_alpha[k]) - fade;
				if (a < -32768)
					a = -32768;
				p_alpha[k] = 16'(a);
			end
			o.slot = 6'(k);
			o.alive = lf > 0;
			o.out_x = p_x[k];
			o.out_y = p_y[k];
			o.out_gray = p_gray[k];
			o.out_alpha = p_alpha[k];
			o.out_width = p_w[k];
			o.out_height = p_h[k];
			o.last_slot = k == NSLOT - 1;
			slot_reports.insert(slot_reports.size(), o);
		end
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (res_valid) begin
				n_results <= n_results + 1;
				if (slot_reports.size() == 0) begin
					if (n_err < MAX_ERR_SHOW)
						$display("unexpected result: %p", res);
					n_err <= n_err + 1;
				end else begin
					if (res !== slot_reports[0]) begin
						if (n_err < MAX_ERR_SHOW)
							$display("mismatch: expected %p actual %p",
								slot_reports[0], res);
						n_err <= n_err + 1;
					end
					void'(slot_reports.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// called at a falling edge; the transaction is taken at the next rising edge
	task automatic send_tick(input in_item_t t);
		while (busy || $urandom_range(99) < idle_pct)
			@(negedge clk);
		item <= t;
		start <= 1'b1;
		@(posedge clk);
		pool_tick(t);
		n_ticks++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain_and_write_fade(input logic [15:0] v);
		while (slot_reports.size() != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		p_fade = v;
	endtask

	function automatic in_item_t rand_tick();
		in_item_t t;
		logic [223:0] rbits;
		rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		t = rbits[$bits(in_item_t)-1:0];
		case ($urandom_range(3))
			0: t.elapsed = 16'($urandom_range(65535));
			default: t.elapsed = 16'($urandom_range(600));
		endcase
		case ($urandom_range(5))
			0: t.spawn_count = 7'd0;
			1: t.spawn_count = 7'($urandom_range(127));
			default: t.spawn_count = 7'($urandom_range(4));
		endcase
		t.gray_level = 13'($urandom_range(4096));
		t.opacity = 13'($urandom_range(4096));
		case ($urandom_range(4))
			0: t.lifetime = 23'd0;
			1: t.lifetime = 23'($urandom_range(8388607));
			default: t.lifetime = 23'($urandom_range(30000));
		endcase
		return t;
	endfunction

	in_item_t dir_tab[$];
	out_item_t first_exp;

	initial begin
		in_item_t t;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		for (int i = 0; i < NSLOT; i++) begin
			p_life[i] = 0; p_x[i] = 0; p_y[i] = 0; p_vx[i] = 0; p_vy[i] = 0;
			p_gray[i] = 0; p_alpha[i] = 0; p_w[i] = 0; p_h[i] = 0;
		end
		p_ptr = 0;
		p_fade = FADE_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed rows: empty tick, extremes, zero lifetime, overfilled pool
		t = '0;
		dir_tab = {dir_tab, t};
		t = '0; t.spawn_count = 7'd1; t.lifetime = 23'h7FFFFF; t.opacity = 13'd4096;
		t.gray_level = 13'd4096; t.spawn_x = 24'sh7FFFFF; t.spawn_y = -24'sh800000;
		t.speed_x = 24'sh7FFFFF; t.speed_y = -24'sh800000;
		t.sprite_width = 16'hFFFF; t.sprite_height = 16'hFFFF; t.elapsed = 16'hFFFF;
		dir_tab = {dir_tab, t};
		t.spawn_count = 7'd3; t.lifetime = 23'd0; t.elapsed = 16'd0;
		dir_tab = {dir_tab, t};
		t.spawn_count = 7'd64; t.lifetime = 23'd5000; t.elapsed = 16'd100;
		dir_tab = {dir_tab, t};
		t.spawn_count = 7'd127; t.lifetime = 23'd9000; t.speed_x = -24'sd3;
		dir_tab = {dir_tab, t};
		t.spawn_count = 7'd2; t.elapsed = 16'hFFFF;
		dir_tab = {dir_tab, t};
		t.spawn_count = 7'd0; t.elapsed = 16'hFFFF;
		dir_tab = {dir_tab, t};
		t = '0; t.spawn_count = 7'd5; t.lifetime = 23'd1; t.elapsed = 16'd1;
		t.opacity = 13'd1;
		dir_tab = {dir_tab, t};

		// empty tick after reset: the expected reports cover every slot, the first one zero and dead
		first_exp = '0;
		first_exp.last_slot = 1'b0;
		send_tick(dir_tab[0]);
		if (slot_reports.size() != NSLOT || slot_reports[0] !== first_exp) begin
			$display("reset pool report wrong: %p", slot_reports[0]);
			n_dir_err++;
		end
		for (int r = 1; r < dir_tab.size(); r++)
			send_tick(dir_tab[r]);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: drain_and_write_fade(16'd0);
				1: drain_and_write_fade(16'hFFFF);
				2: drain_and_write_fade(16'(FADE_RESET));
				default: drain_and_write_fade(16'($urandom_range(65535)));
			endcase
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 54;
				default: idle_pct = 25;
			endcase
			for (int n = 0; n < 77; n++)
				send_tick(rand_tick());
		end

		while (slot_reports.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		$display("%0d ticks, %0d slot reports, fade rates 0, max, reset and random",
			n_ticks, n_results);
		if (n_err == 0 && n_dir_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
